>>> hw/rtl/bloom_filter_jenkins_mix_macros.svh
// Assertion helpers for the top-level module, which checks its own logic.
`ifndef BLOOM_FILTER_JENKINS_MIX_MACROS_SVH
`define BLOOM_FILTER_JENKINS_MIX_MACROS_SVH

// Same-cycle implication.
`define BFJM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BFJM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bfjm_pkg.sv
package bfjm_pkg;

	localparam int MAX_BITS = 4096;
	localparam int NUM_KEYS = 4;
	localparam int KEY_REGS = 4;

	localparam int WORD_W = 32;
	localparam int HKEY_W = 64;
	localparam int FB_W = 13;
	localparam int CFG_IDX_W = 3;
	localparam int KREG_W = 2;

	// bit index and modulus widths
	localparam int BIT_W = $clog2(MAX_BITS);
	localparam int N_W = $clog2(MAX_BITS + 1);

	// bit store arranged as rows, one valid flop per row
	localparam int ROW_W = (MAX_BITS < 64) ? MAX_BITS : 64;
	localparam int COL_W = (ROW_W > 1) ? $clog2(ROW_W) : 1;
	localparam int ROWS = (MAX_BITS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam int KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int STEP_W = $clog2(WORD_W);
	localparam int MIX_STEPS = 9;
	localparam int MIX_IDX_W = $clog2(MIX_STEPS);

	localparam logic [FB_W-1:0] FILTER_BITS_RST = FB_W'(4096);
	localparam logic [HKEY_W-1:0] HASH_KEY_RST = HKEY_W'(123);

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_0 = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_3 = CFG_IDX_W'(4);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MIX,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ROLE_A,
		ROLE_B,
		ROLE_C
	} role_t;

	typedef struct packed {
		logic start;
		logic load;
		logic mix;
		logic mod;
		logic rd;
		logic chk;
		logic [KEY_W-1:0] key;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic kind;
	} stat_t;

	// which of a, b, c a mix step rewrites
	function automatic role_t mix_role(input logic [MIX_IDX_W-1:0] s);
		role_t r;
		case (s)
			MIX_IDX_W'(0), MIX_IDX_W'(3), MIX_IDX_W'(6): r = ROLE_A;
			MIX_IDX_W'(1), MIX_IDX_W'(4), MIX_IDX_W'(7): r = ROLE_B;
			default: r = ROLE_C;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] mix_shift(input logic [MIX_IDX_W-1:0] s);
		logic [4:0] sh;
		case (s)
			MIX_IDX_W'(0): sh = 5'd13;
			MIX_IDX_W'(1): sh = 5'd8;
			MIX_IDX_W'(2): sh = 5'd13;
			MIX_IDX_W'(3): sh = 5'd12;
			MIX_IDX_W'(4): sh = 5'd16;
			MIX_IDX_W'(5): sh = 5'd5;
			MIX_IDX_W'(6): sh = 5'd3;
			MIX_IDX_W'(7): sh = 5'd10;
			MIX_IDX_W'(8): sh = 5'd15;
			default: sh = 5'd0;
		endcase
		return sh;
	endfunction

endpackage

>>> hw/rtl/bfjm_ram.sv
module bfjm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/bfjm_dp.sv
module bfjm_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bfjm_pkg::cmd_t                     cmd,
	output bfjm_pkg::stat_t                    stat,
	input  logic                               kind,
	input  logic [bfjm_pkg::WORD_W-1:0]        item_key,
	input  logic                               cfg_we,
	input  logic [bfjm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfjm_pkg::HKEY_W-1:0]        cfg_data,
	output logic                               present
);

	logic [bfjm_pkg::FB_W-1:0]     filter_bits_q;
	logic [bfjm_pkg::HKEY_W-1:0]   hash_key_q [bfjm_pkg::KEY_REGS];
	logic [bfjm_pkg::CFG_IDX_W-1:0] key_wr_idx;

	logic                          kind_q;
	logic [bfjm_pkg::WORD_W-1:0]   item_key_q;
	logic [bfjm_pkg::N_W-1:0]      n_q;
	logic [bfjm_pkg::N_W-1:0]      n_eff;
	logic [bfjm_pkg::WORD_W-1:0]   a_q, b_q, c_q;
	logic [bfjm_pkg::BIT_W-1:0]    rem_q;
	logic                          all_set_q;

	logic [bfjm_pkg::HKEY_W-1:0]   key_word;
	bfjm_pkg::role_t               role;
	logic [4:0]                    sh;
	logic [bfjm_pkg::WORD_W-1:0]   t, p, q, sub, mixed;

	logic [bfjm_pkg::BIT_W:0]      rem_sh;
	logic [bfjm_pkg::BIT_W:0]      n_ext;

	logic [bfjm_pkg::ROWS-1:0]     valid_q;
	logic                          rd_valid_s1;
	logic [bfjm_pkg::ROW_AW-1:0]   row;
	logic [bfjm_pkg::COL_W-1:0]    col;
	logic [bfjm_pkg::ROW_W-1:0]    ram_rdata;
	logic [bfjm_pkg::ROW_W-1:0]    row_data;
	logic [bfjm_pkg::ROW_W-1:0]    row_wdata;
	logic                          ram_we;

	// configuration registers
	assign key_wr_idx = cfg_index - bfjm_pkg::REG_HASH_KEY_0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bits_q <= bfjm_pkg::FILTER_BITS_RST;
			for (int i = 0; i < bfjm_pkg::KEY_REGS; i++) begin
				hash_key_q[i] <= bfjm_pkg::HASH_KEY_RST;
			end
		end else if (cfg_we) begin
			if (cfg_index == bfjm_pkg::REG_FILTER_BITS) begin
				filter_bits_q <= cfg_data[bfjm_pkg::FB_W-1:0];
			end else if (cfg_index inside
					{[bfjm_pkg::REG_HASH_KEY_0:bfjm_pkg::REG_HASH_KEY_3]}) begin
				hash_key_q[key_wr_idx[bfjm_pkg::KREG_W-1:0]] <= cfg_data;
			end
		end
	end

	// zero acts as one, oversize saturates
	always_comb begin
		if (filter_bits_q == '0) begin
			n_eff = bfjm_pkg::N_W'(1);
		end else if (32'(filter_bits_q) > 32'(bfjm_pkg::MAX_BITS)) begin
			n_eff = bfjm_pkg::N_W'(bfjm_pkg::MAX_BITS);
		end else begin
			n_eff = bfjm_pkg::N_W'(filter_bits_q);
		end
	end

	// one mix row per cycle
	assign key_word = hash_key_q[bfjm_pkg::KREG_W'(cmd.key)];
	assign role = bfjm_pkg::mix_role(cmd.step[bfjm_pkg::MIX_IDX_W-1:0]);
	assign sh = bfjm_pkg::mix_shift(cmd.step[bfjm_pkg::MIX_IDX_W-1:0]);

	always_comb begin
		case (role)
			bfjm_pkg::ROLE_A: begin
				t = a_q; p = b_q; q = c_q;
			end
			bfjm_pkg::ROLE_B: begin
				t = b_q; p = c_q; q = a_q;
			end
			default: begin
				t = c_q; p = a_q; q = b_q;
			end
		endcase
		sub = t - p - q;
		if (role == bfjm_pkg::ROLE_B) begin
			mixed = sub ^ (q << sh);
		end else begin
			mixed = sub ^ (q >> sh);
		end
	end

	// restoring remainder, one dividend bit per cycle
	assign rem_sh = {rem_q, c_q[bfjm_pkg::WORD_W-1]};
	assign n_ext = (bfjm_pkg::BIT_W + 1)'(n_q);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q <= kind;
			item_key_q <= item_key;
			n_q <= n_eff;
			all_set_q <= 1'b1;
		end
		if (cmd.load) begin
			a_q <= key_word[bfjm_pkg::WORD_W-1:0];
			b_q <= key_word[bfjm_pkg::HKEY_W-1:bfjm_pkg::WORD_W];
			c_q <= item_key_q;
			rem_q <= '0;
		end
		if (cmd.mix) begin
			case (role)
				bfjm_pkg::ROLE_A: a_q <= mixed;
				bfjm_pkg::ROLE_B: b_q <= mixed;
				default: c_q <= mixed;
			endcase
		end
		if (cmd.mod) begin
			c_q <= c_q << 1;
			if (rem_sh >= n_ext) begin
				rem_q <= bfjm_pkg::BIT_W'(rem_sh - n_ext);
			end else begin
				rem_q <= bfjm_pkg::BIT_W'(rem_sh);
			end
		end
		if (cmd.chk && !kind_q) begin
			all_set_q <= all_set_q & row_data[col];
		end
	end

	// bit store: rows never written read as zero
	assign row = bfjm_pkg::ROW_AW'(rem_q >> bfjm_pkg::COL_W);
	assign col = bfjm_pkg::COL_W'(rem_q);
	assign ram_we = cmd.chk & kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[row] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_valid_s1 <= valid_q[row];
		end
	end

	always_comb begin
		row_data = rd_valid_s1 ? ram_rdata : '0;
		row_wdata = row_data;
		row_wdata[col] = 1'b1;
	end

	bfjm_ram #(
		.WIDTH(bfjm_pkg::ROW_W),
		.DEPTH(bfjm_pkg::ROWS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row),
		.wdata (row_wdata),
		.re    (cmd.rd),
		.raddr (row),
		.rdata (ram_rdata)
	);

	assign stat.kind = kind_q;
	assign present = all_set_q;

endmodule

>>> hw/rtl/bfjm_ctrl.sv
module bfjm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            result_valid,
	output bfjm_pkg::cmd_t  cmd,
	input  bfjm_pkg::stat_t stat
);

	bfjm_pkg::state_t state_q, state_d;
	logic [bfjm_pkg::KEY_W-1:0]  key_q, key_d;
	logic [bfjm_pkg::STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfjm_pkg::ST_IDLE;
			key_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			key_q <= key_d;
			step_q <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		key_d = key_q;
		step_d = step_q;
		cmd = '0;
		cmd.key = key_q;
		cmd.step = step_q;
		busy = (state_q != bfjm_pkg::ST_IDLE);
		result_valid = 1'b0;
		case (state_q)
			bfjm_pkg::ST_IDLE: begin
				if (start) begin
					cmd.start = 1'b1;
					key_d = '0;
					state_d = bfjm_pkg::ST_LOAD;
				end
			end
			bfjm_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				step_d = '0;
				state_d = bfjm_pkg::ST_MIX;
			end
			bfjm_pkg::ST_MIX: begin
				cmd.mix = 1'b1;
				if (step_q == bfjm_pkg::STEP_W'(bfjm_pkg::MIX_STEPS - 1)) begin
					step_d = '0;
					state_d = bfjm_pkg::ST_MOD;
				end else begin
					step_d = step_q + bfjm_pkg::STEP_W'(1);
				end
			end
			bfjm_pkg::ST_MOD: begin
				cmd.mod = 1'b1;
				if (step_q == bfjm_pkg::STEP_W'(bfjm_pkg::WORD_W - 1)) begin
					step_d = '0;
					state_d = bfjm_pkg::ST_READ;
				end else begin
					step_d = step_q + bfjm_pkg::STEP_W'(1);
				end
			end
			bfjm_pkg::ST_READ: begin
				cmd.rd = 1'b1;
				state_d = bfjm_pkg::ST_CHECK;
			end
			bfjm_pkg::ST_CHECK: begin
				cmd.chk = 1'b1;
				if (key_q == bfjm_pkg::KEY_W'(bfjm_pkg::NUM_KEYS - 1)) begin
					state_d = bfjm_pkg::ST_DONE;
				end else begin
					key_d = key_q + bfjm_pkg::KEY_W'(1);
					state_d = bfjm_pkg::ST_LOAD;
				end
			end
			bfjm_pkg::ST_DONE: begin
				// inserts finish silently
				result_valid = !stat.kind;
				state_d = bfjm_pkg::ST_IDLE;
			end
			default: begin
				state_d = bfjm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/bloom_filter_jenkins_mix.sv
// Bloom filter, 32-bit item keys hashed by a Jenkins 96-bit mix per hash key.
// Command channel: drive kind (1 insert, 0 query) and item_key with start; the
// transaction is taken at a clock edge where start is high and busy is low.
// Result channel: for a query, present is shown for one cycle with
// result_valid high. Inserts give no result. The receiver cannot stall.
// Configuration: cfg_index/cfg_data taken when cfg_valid and cfg_ready are
// high; cfg_ready is low while busy or start is high. Index 0 filter_bits,
// 1..4 hash keys.
// Each hash key runs through load, 9 mix rows, 32 remainder steps in the
// shift-subtract unit, row read, and check or write-back. A new start is
// taken only once the previous transaction is done and busy is low.
// Reset clears the bit store at once through per-row valid flags (64 rows of
// 64 bits), so the block accepts commands in the first cycle after reset, and
// restores filter_bits to 4096 and every hash key to 123.
`include "bloom_filter_jenkins_mix_macros.svh"

module bloom_filter_jenkins_mix (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               kind,
	input  logic [bfjm_pkg::WORD_W-1:0]        item_key,
	output logic                               result_valid,
	output logic                               present,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfjm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfjm_pkg::HKEY_W-1:0]        cfg_data
);

	bfjm_pkg::cmd_t  cmd;
	bfjm_pkg::stat_t stat;
	logic            cfg_we;

	// a register write never lands on the edge that takes a command
	assign cfg_ready = !busy && !start;
	assign cfg_we = cfg_valid & cfg_ready;

	bfjm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.result_valid (result_valid),
		.cmd          (cmd),
		.stat         (stat)
	);

	bfjm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.kind      (kind),
		.item_key  (item_key),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.present   (present)
	);

	`BFJM_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
	`BFJM_ASSERT_NOW(a_result_busy, clk, arst_n, result_valid, busy, "result while idle")
	`BFJM_ASSERT_NEXT(a_result_single, clk, arst_n, result_valid, !result_valid && !busy, "result not single")
	`BFJM_ASSERT_NOW(a_cmd_excl, clk, arst_n, cmd.chk || cmd.rd, !cmd.mix && !cmd.mod && !cmd.load, "overlapping commands")

endmodule

>>> tb/bloom_filter_jenkins_mix_tb.sv
`timescale 1ns / 100ps

module bloom_filter_jenkins_mix_tb;

	localparam int MAX_BITS = bfjm_pkg::MAX_BITS;
	localparam int NUM_KEYS = bfjm_pkg::NUM_KEYS;
	localparam int KEY_REGS = bfjm_pkg::KEY_REGS;
	localparam int WORD_W = bfjm_pkg::WORD_W;
	localparam int HKEY_W = bfjm_pkg::HKEY_W;
	localparam int FB_W = bfjm_pkg::FB_W;
	localparam int CFG_IDX_W = bfjm_pkg::CFG_IDX_W;
	localparam int BIT_W = bfjm_pkg::BIT_W;
	localparam logic [FB_W-1:0] FILTER_BITS_RST = bfjm_pkg::FILTER_BITS_RST;
	localparam logic [HKEY_W-1:0] HASH_KEY_RST = bfjm_pkg::HASH_KEY_RST;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = bfjm_pkg::REG_FILTER_BITS;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_0 = bfjm_pkg::REG_HASH_KEY_0;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_KEY_3 = bfjm_pkg::REG_HASH_KEY_3;

	localparam logic KIND_QUERY = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(REG_HASH_KEY_3 + 1);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
	localparam int REG_COUNT = KEY_REGS + 1;

	localparam int CFG_SETTLE = 200;     // an insert may still be in flight
	localparam int END_DRAIN = 200;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 75;
	localparam int DIR_ROWS = 35;

	typedef enum logic [1:0] {
		ROW_QUERY,
		ROW_INSERT,
		ROW_WRITE
	} row_op_t;

	typedef struct packed {
		row_op_t op;
		logic [CFG_IDX_W-1:0] idx;
		logic [HKEY_W-1:0] val;
		logic fixed;
		logic want;
	} stim_row_t;

	typedef struct {
		logic [WORD_W-1:0] key;
		logic present;
	} query_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic kind = KIND_QUERY;
	logic [WORD_W-1:0] item_key = '0;
	logic result_valid;
	logic present;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [HKEY_W-1:0] cfg_data = '0;

	// predictor state
	logic [FB_W-1:0] filter_bits_q = FILTER_BITS_RST;
	logic [HKEY_W-1:0] hkey_model [KEY_REGS];
	logic [MAX_BITS-1:0] filter_store = '0;

	query_rec_t present_q [$];
	query_rec_t head_rec;
	logic gaps_on = 1'b0;
	int fail_cnt = 0;
	int insert_cnt = 0;
	int query_cnt = 0;
	int hit_cnt = 0;
	int write_cnt = 0;
	int stall_cycles = 0;

	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{ROW_QUERY, '0, 64'h0, 1'b1, 1'b0},
		'{ROW_QUERY, '0, 64'hFFFF_FFFF, 1'b1, 1'b0},
		'{ROW_INSERT, '0, 64'h0, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h0, 1'b1, 1'b1},
		'{ROW_INSERT, '0, 64'hFFFF_FFFF, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'hFFFF_FFFF, 1'b1, 1'b1},
		'{ROW_QUERY, '0, 64'h1234_5678, 1'b0, 1'b0},
		'{ROW_INSERT, '0, 64'h8000_0000, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h8000_0000, 1'b1, 1'b1},
		'{ROW_QUERY, '0, 64'h0000_0001, 1'b0, 1'b0},
		// writes past the register list leave everything as it was
		'{ROW_WRITE, REG_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{ROW_WRITE, REG_SPARE_LO + 3'd1, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0},
		'{ROW_WRITE, REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h0, 1'b1, 1'b1},
		// zero bit count: every key lands on bit 0
		'{ROW_WRITE, REG_FILTER_BITS, 64'h0, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h7, 1'b0, 1'b0},
		'{ROW_INSERT, '0, 64'h7, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h5555_AAAA, 1'b1, 1'b1},
		// oversized bit count behaves as the full store
		'{ROW_WRITE, REG_FILTER_BITS, 64'h1FFF, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h8000_0000, 1'b1, 1'b1},
		'{ROW_WRITE, REG_FILTER_BITS, 64'h1, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'hDEAD_BEEF, 1'b1, 1'b1},
		'{ROW_WRITE, REG_FILTER_BITS, 64'd97, 1'b0, 1'b0},
		'{ROW_WRITE, REG_HASH_KEY_0, 64'h0, 1'b0, 1'b0},
		'{ROW_WRITE, REG_HASH_KEY_0 + 3'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{ROW_WRITE, REG_HASH_KEY_0 + 3'd2, 64'h8000_0000_0000_0000, 1'b0, 1'b0},
		'{ROW_WRITE, REG_HASH_KEY_3, 64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'hAAAA_AAAA, 1'b0, 1'b0},
		'{ROW_INSERT, '0, 64'hAAAA_AAAA, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'hAAAA_AAAA, 1'b1, 1'b1},
		'{ROW_QUERY, '0, 64'h5555_5555, 1'b0, 1'b0},
		'{ROW_WRITE, REG_FILTER_BITS, 64'h1000, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h0, 1'b0, 1'b0},
		'{ROW_INSERT, '0, 64'h7FFF_FFFF, 1'b0, 1'b0},
		'{ROW_QUERY, '0, 64'h7FFF_FFFF, 1'b1, 1'b1}
	};

	bloom_filter_jenkins_mix i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.item_key(item_key),
		.result_valid(result_valid),
		.present(present),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] jenkins_mix(input logic [HKEY_W-1:0] hk,
			input logic [WORD_W-1:0] c_in);
		logic [WORD_W-1:0] a, b, c;
		a = hk[31:0];
		b = hk[63:32];
		c = c_in;
		a = a - b - c; a = a ^ (c >> 13);
		b = b - c - a; b = b ^ (a << 8);
		c = c - a - b; c = c ^ (b >> 13);
		a = a - b - c; a = a ^ (c >> 12);
		b = b - c - a; b = b ^ (a << 16);
		c = c - a - b; c = c ^ (b >> 5);
		a = a - b - c; a = a ^ (c >> 3);
		b = b - c - a; b = b ^ (a << 10);
		c = c - a - b; c = c ^ (b >> 15);
		return c;
	endfunction

	// sets or tests the selected bits; returns the membership answer
	function automatic logic filter_apply(input logic k, input logic [WORD_W-1:0] key);
		logic [31:0] n;
		logic [31:0] idx;
		logic hit;
		hit = 1'b1;
		if (filter_bits_q == '0)
			n = 32'd1;
		else if (filter_bits_q > MAX_BITS)
			n = 32'(MAX_BITS);
		else
			n = 32'(filter_bits_q);
		for (int i = 0; i < NUM_KEYS; i++) begin
			idx = jenkins_mix(hkey_model[i], key) % n;
			if (k == KIND_INSERT)
				filter_store[idx[BIT_W-1:0]] = 1'b1;
			else if (!filter_store[idx[BIT_W-1:0]])
				hit = 1'b0;
		end
		return hit;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HKEY_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_FILTER_BITS)
			filter_bits_q = data[FB_W-1:0];
		else if (idx >= REG_HASH_KEY_0 && idx <= REG_HASH_KEY_3)
			hkey_model[idx - REG_HASH_KEY_0] = data;
		write_cnt++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// entered at a falling edge; returns at the falling edge after the command is taken
	task automatic issue(input logic k, input logic [WORD_W-1:0] key, input logic fixed,
			input logic want);
		int unsigned hold;
		logic p;
		query_rec_t rec;
		hold = 0;
		start <= 1'b1;
		kind <= k;
		item_key <= key;
		forever begin
			@(posedge clk);
			if (start && !busy)
				break;
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				if (hold == 0)
					start <= 1'b1;
			end else if (gaps_on && $urandom_range(63) == 0) begin
				hold = $urandom_range(3, 1);
				start <= 1'b0;
			end
		end
		p = filter_apply(k, key);
		if (k == KIND_QUERY) begin
			rec.key = key;
			rec.present = fixed ? want : p;
			present_q.insert(present_q.size(), rec);
			query_cnt++;
		end else begin
			insert_cnt++;
		end
		@(negedge clk);
	endtask

	// idle the block before touching its registers
	task automatic settle();
		start <= 1'b0;
		while (present_q.size() != 0)
			@(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (present_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual present=%0b",
					$time, present);
				fail_cnt++;
			end else begin
				head_rec = present_q.pop_front();
				if (present === 1'b1)
					hit_cnt++;
				if (present !== head_rec.present) begin
					$display("%0t: key %h present expected %0b actual %0b",
						$time, head_rec.key, head_rec.present, present);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, giving up", $time, stall_cycles);
			$display("Some tests failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic prev_item;
		logic [FB_W-1:0] fb;
		logic [HKEY_W-1:0] hk;
		logic [CFG_IDX_W-1:0] idx;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] phase_keys [$];
		int unsigned off;
		int unsigned r;

		for (int i = 0; i < KEY_REGS; i++)
			hkey_model[i] = HASH_KEY_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		prev_item = 1'b1;
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (DIR_TAB[i].op == ROW_WRITE) begin
				if (prev_item)
					settle();
				write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
				prev_item = 1'b0;
			end else begin
				issue(DIR_TAB[i].op == ROW_INSERT ? KIND_INSERT : KIND_QUERY,
					DIR_TAB[i].val[WORD_W-1:0], DIR_TAB[i].fixed, DIR_TAB[i].want);
				prev_item = 1'b1;
			end
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			settle();
			case (p)
				1: fb = '0;
				3: fb = '1;
				5: fb = FB_W'(1);
				default: begin
					case ($urandom_range(3))
						0: fb = FB_W'($urandom_range(16, 2));
						1: fb = FB_W'($urandom_range(512, 17));
						2: fb = FB_W'($urandom_range(4096, 513));
						default: fb = FB_W'($urandom_range(8191, 4097));
					endcase
				end
			endcase
			off = $urandom_range(REG_COUNT - 1);
			for (int j = 0; j < REG_COUNT; j++) begin
				idx = CFG_IDX_W'((off + j) % REG_COUNT);
				if (idx == REG_FILTER_BITS) begin
					write_reg(idx, {$urandom, 19'($urandom), fb});
				end else begin
					case ($urandom_range(5))
						0: hk = '0;
						1: hk = '1;
						2: hk = HASH_KEY_RST;
						default: hk = {$urandom, $urandom};
					endcase
					write_reg(idx, hk);
				end
			end
			if ($urandom_range(2) == 0)
				write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)),
					{$urandom, $urandom});

			// no idling in the closing phase
			gaps_on = (p != RAND_PHASES - 1) && ($urandom_range(3) != 0);
			phase_keys.delete();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				r = $urandom_range(9);
				key = $urandom;
				if ($urandom_range(15) == 0)
					key = $urandom_range(1) ? '1 : '0;
				if (r < 4) begin
					phase_keys.insert(phase_keys.size(), key);
					issue(KIND_INSERT, key, 1'b0, 1'b0);
				end else if (phase_keys.size() != 0 && r < 7) begin
					issue(KIND_QUERY, phase_keys[$urandom_range(phase_keys.size() - 1)],
						1'b0, 1'b0);
				end else if (phase_keys.size() != 0 && r == 9) begin
					// one bit away from a known member
					key = phase_keys[$urandom_range(phase_keys.size() - 1)]
						^ (32'd1 << $urandom_range(31));
					issue(KIND_QUERY, key, 1'b0, 1'b0);
				end else begin
					issue(KIND_QUERY, key, 1'b0, 1'b0);
				end
				if (gaps_on && $urandom_range(3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(3, 1)) @(negedge clk);
				end
			end
		end

		start <= 1'b0;
		while (present_q.size() != 0)
			@(negedge clk);
		repeat (END_DRAIN) @(negedge clk);
		if (present_q.size() != 0) begin
			$display("%0t: %0d queries never answered", $time, present_q.size());
			fail_cnt++;
		end

		$display("Covered %0d inserts and %0d queries (%0d answered present)",
			insert_cnt, query_cnt, hit_cnt);
		$display("over %0d register writes and %0d random filter settings",
			write_cnt, RAND_PHASES);
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
